/* src/scba_pkg.sv */
`timescale 1ns / 1ps

package scba_pkg;

  // sizes of the block
  localparam int CLASS_COUNT      = 12;
  localparam int SIZE_INDEX_COUNT = 20;
  localparam int MAP_WORDS        = 146;
  localparam int OFFSET_BITS      = 25;

  // field widths
  localparam int REQ_W      = 24;
  localparam int REL_W      = 25;
  localparam int ST_W       = 2;
  localparam int MAP_BITS   = 64;
  localparam int BIT_W      = $clog2(MAP_BITS);
  localparam int IN_DATA_W  = ((REQ_W + REL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OFFSET_BITS + ST_W + 7) / 8) * 8;

  // status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BADADDR = 2'd2;
  localparam logic [ST_W-1:0] ST_DOUBLE  = 2'd3;

  // class layout
  typedef int class_int_t [CLASS_COUNT];
  typedef int size_int_t [SIZE_INDEX_COUNT];

  localparam class_int_t CLASS_LOG_TBL    = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 19};
  localparam class_int_t CLASS_CHUNKS_TBL = '{4096, 2048, 1024, 512, 256, 256,
                                              256, 256, 256, 256, 64, 32};
  localparam size_int_t SIZE_TO_CLASS = '{0, 0, 0, 0, 1, 2, 3, 4, 5, 6,
                                          7, 8, 9, 10, 11, 11, 11, 11, 11, 11};

  function automatic longint class_bytes(input int c);
    return longint'(CLASS_CHUNKS_TBL[c]) << CLASS_LOG_TBL[c];
  endfunction

  function automatic longint class_base(input int c);
    longint b;
    b = 0;
    for (int j = 0; j < c && j < CLASS_COUNT; j++) b += class_bytes(j);
    return b;
  endfunction

  function automatic int class_words(input int c);
    return (CLASS_CHUNKS_TBL[c] + 63) / 64;
  endfunction

  function automatic int class_word_base(input int c);
    int w;
    w = 0;
    for (int j = 0; j < c && j < CLASS_COUNT; j++) w += class_words(j);
    return w;
  endfunction

  function automatic int max_class_words();
    int m;
    m = 1;
    for (int j = 0; j < CLASS_COUNT; j++) if (class_words(j) > m) m = class_words(j);
    return m;
  endfunction

  function automatic int max_class_log();
    int m;
    m = 0;
    for (int j = 0; j < CLASS_COUNT; j++) if (CLASS_LOG_TBL[j] > m) m = CLASS_LOG_TBL[j];
    return m;
  endfunction

  // derived widths
  localparam longint REGION_END  = class_base(CLASS_COUNT);
  localparam int     BASE_W      = $clog2(REGION_END + 1);
  localparam int     REL_CMP_W   = (BASE_W > REL_W) ? BASE_W : REL_W;
  localparam int     MAXW        = max_class_words();
  localparam int     IDX_W       = (MAXW > 1) ? $clog2(MAXW) : 1;
  localparam int     CNT_W       = IDX_W + 1;
  localparam int     CHUNK_W     = IDX_W + BIT_W;
  localparam int     CHN_W       = CHUNK_W + 1;
  localparam int     LOG_W       = $clog2(max_class_log() + 1);
  localparam int     WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int     TOTAL_WORDS = class_word_base(CLASS_COUNT);
  localparam int     WSUM_RAW    = $clog2(TOTAL_WORDS + MAXW + 1);
  localparam int     WSUM_W      = (WSUM_RAW > WORD_W) ? WSUM_RAW : WORD_W;
  localparam int     CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int     L_W         = $clog2(SIZE_INDEX_COUNT);

  // constant tables for the datapath
  typedef logic [BASE_W-1:0] base_tbl_t [CLASS_COUNT];
  typedef logic [WSUM_W-1:0] wbase_tbl_t [CLASS_COUNT];
  typedef logic [CNT_W-1:0]  cnt_tbl_t [CLASS_COUNT];
  typedef logic [CHN_W-1:0]  chn_tbl_t [CLASS_COUNT];
  typedef logic [LOG_W-1:0]  log_tbl_t [CLASS_COUNT];

  function automatic base_tbl_t build_base();
    base_tbl_t t;
    for (int c = 0; c < CLASS_COUNT; c++) t[c] = BASE_W'(class_base(c));
    return t;
  endfunction

  function automatic base_tbl_t build_bytes();
    base_tbl_t t;
    for (int c = 0; c < CLASS_COUNT; c++) t[c] = BASE_W'(class_bytes(c));
    return t;
  endfunction

  function automatic wbase_tbl_t build_wbase();
    wbase_tbl_t t;
    for (int c = 0; c < CLASS_COUNT; c++) t[c] = WSUM_W'(class_word_base(c));
    return t;
  endfunction

  function automatic cnt_tbl_t build_words();
    cnt_tbl_t t;
    for (int c = 0; c < CLASS_COUNT; c++) t[c] = CNT_W'(class_words(c));
    return t;
  endfunction

  function automatic chn_tbl_t build_chunks();
    chn_tbl_t t;
    for (int c = 0; c < CLASS_COUNT; c++) t[c] = CHN_W'(CLASS_CHUNKS_TBL[c]);
    return t;
  endfunction

  function automatic log_tbl_t build_log();
    log_tbl_t t;
    for (int c = 0; c < CLASS_COUNT; c++) t[c] = LOG_W'(CLASS_LOG_TBL[c]);
    return t;
  endfunction

  localparam base_tbl_t  CLASS_BASE   = build_base();
  localparam base_tbl_t  CLASS_BYTES  = build_bytes();
  localparam wbase_tbl_t WORD_BASE    = build_wbase();
  localparam cnt_tbl_t   CLASS_WORDS  = build_words();
  localparam chn_tbl_t   CLASS_CHUNKS = build_chunks();
  localparam log_tbl_t   CLASS_LOG    = build_log();

endpackage

/* src/size_class_bitmap_allocator_unit.sv */
`timescale 1ns / 1ps

// size-class bitmap allocator
// input channel s_axis: one command word per request; tuser is the command
// (0 allocate, 1 free), tdata carries the request size and the release offset.
// output channel m_axis: one result word per command, chunk offset and status.
// the used bitmap lives in a one-port-read, one-port-write memory; allocation
// scans the words of the chosen class one per cycle through that read port.
// steps from input accept to output valid: a free takes S_F_CLASS, S_F_DIFF,
// S_F_IDX, S_F_CHK, S_DONE, and goes from S_F_DIFF to S_DONE when the address
// lies beyond the region; an allocation takes S_A_CLASS, S_A_START, S_A_SCAN
// per word scanned (1 to 64; 64 for the 8-byte class), S_A_HIT, S_A_OFF and
// S_DONE; a full class leaves the scan for S_DONE, too large a size S_A_CLASS.
// one command is in work at a time; tready is low until its result has been
// handed to the output register, and the next command can be accepted in the
// cycle after that.
// a finished result sits in the output register while the receiver stalls;
// the next command is accepted and worked on meanwhile, and only waits at the
// end for the output register to drain.
// reset leaves every chunk free at once (per-word valid bits, no clearing
// pass) and the output empty.
module size_class_bitmap_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // request_size [23:0], release_offset [48:24], zero fill
  input  logic [scba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // chunk_offset [24:0], status [26:25], zero fill
  output logic [scba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import scba_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_A_CLASS = 4'd1;
  localparam logic [3:0] S_A_START = 4'd2;
  localparam logic [3:0] S_A_SCAN  = 4'd3;
  localparam logic [3:0] S_A_HIT   = 4'd4;
  localparam logic [3:0] S_A_OFF   = 4'd5;
  localparam logic [3:0] S_F_CLASS = 4'd6;
  localparam logic [3:0] S_F_DIFF  = 4'd7;
  localparam logic [3:0] S_F_IDX   = 4'd8;
  localparam logic [3:0] S_F_CHK   = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]             state_q, state_d;
  logic [REQ_W-1:0]       size_q, size_d;
  logic [REL_W-1:0]       addr_q, addr_d;
  logic [CLS_W-1:0]       cls_q, cls_d;
  logic [IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic [WSUM_W-1:0]      chk_addr_q, chk_addr_d;
  logic [MAP_BITS-1:0]    hit_word_q, hit_word_d;
  logic [MAP_BITS-1:0]    free_q, free_d;
  logic [CHUNK_W-1:0]     chunk_q, chunk_d;
  logic [BASE_W-1:0]      diff_q, diff_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [OFFSET_BITS-1:0] res_off_q, res_off_d;
  logic [ST_W-1:0]        res_st_q, res_st_d;
  logic                   m_valid_q, m_valid_d;
  logic [OFFSET_BITS-1:0] out_off_q, out_off_d;
  logic [ST_W-1:0]        out_st_q, out_st_d;

  // bitmap memory with per-word valid bits
  logic [MAP_BITS-1:0]    mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0]   vld_q;
  logic [MAP_BITS-1:0]    rdata_q;
  logic                   rvld_q;
  logic                   rd_en;
  logic [WORD_W-1:0]      rd_addr;
  logic                   we;
  logic [WORD_W-1:0]      wr_addr;
  logic [MAP_BITS-1:0]    wr_data;
  logic [MAP_BITS-1:0]    rd_word;

  // datapath helpers
  logic [L_W-1:0]         size_log;
  logic                   size_big;
  int                     size_cls;
  logic [CLS_W-1:0]       free_cls;
  logic [CHN_W-1:0]       left;
  logic [MAP_BITS-1:0]    vmask;
  logic [MAP_BITS-1:0]    freebits;
  logic [WSUM_W-1:0]      next_addr;
  logic [BASE_W-1:0]      alloc_off;
  logic [REL_CMP_W-1:0]   diff_full;
  logic [CHUNK_W-1:0]     fidx;
  logic [WSUM_W-1:0]      fword;
  logic                   in_acc;

  function automatic logic [BIT_W-1:0] first_set(input logic [MAP_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) if (v[i]) r = BIT_W'(i);
    return r;
  endfunction

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_st_q, out_off_q});
  assign rd_word       = rvld_q ? rdata_q : '0;

  // ceil log2 of the request size by threshold compares
  always_comb begin
    size_log = '0;
    for (int k = 0; k < SIZE_INDEX_COUNT - 1; k++) begin
      if (64'(size_q) > (64'd1 << k)) size_log = L_W'(k + 1);
    end
    size_big = 64'(size_q) > (64'd1 << (SIZE_INDEX_COUNT - 1));
    size_cls = SIZE_TO_CLASS[size_log];
  end

  // class of a release address: highest base not above it
  always_comb begin
    free_cls = '0;
    for (int j = 1; j < CLASS_COUNT; j++) begin
      if (REL_CMP_W'(CLASS_BASE[j]) <= REL_CMP_W'(addr_q)) free_cls = CLS_W'(j);
    end
  end

  // scan word masking and free bit search
  assign left      = CLASS_CHUNKS[cls_q] - CHN_W'({chk_idx_q, {BIT_W{1'b0}}});
  assign vmask     = (left >= CHN_W'(MAP_BITS)) ? '1
                   : ((MAP_BITS'(1) << left[BIT_W-1:0]) - MAP_BITS'(1));
  assign freebits  = ~rd_word & vmask;
  assign next_addr = chk_addr_q + WSUM_W'(1);

  // offset arithmetic
  assign alloc_off = CLASS_BASE[cls_q] + (BASE_W'(chunk_q) << CLASS_LOG[cls_q]);
  assign diff_full = REL_CMP_W'(addr_q) - REL_CMP_W'(CLASS_BASE[cls_q]);
  assign fidx      = CHUNK_W'(diff_q >> CLASS_LOG[cls_q]);
  assign fword     = WORD_BASE[cls_q] + WSUM_W'(fidx[CHUNK_W-1:BIT_W]);

  // sequencer
  always_comb begin
    state_d    = state_q;
    size_d     = size_q;
    addr_d     = addr_q;
    cls_d      = cls_q;
    chk_idx_d  = chk_idx_q;
    chk_addr_d = chk_addr_q;
    hit_word_d = hit_word_q;
    free_d     = free_q;
    chunk_d    = chunk_q;
    diff_d     = diff_q;
    bit_d      = bit_q;
    res_off_d  = res_off_q;
    res_st_d   = res_st_q;
    m_valid_d  = m_valid_q;
    out_off_d  = out_off_q;
    out_st_d   = out_st_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    we         = 1'b0;
    wr_addr    = chk_addr_q[WORD_W-1:0];
    wr_data    = hit_word_q;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          size_d  = s_axis_tdata[REQ_W-1:0];
          addr_d  = s_axis_tdata[REQ_W+REL_W-1:REQ_W];
          state_d = s_axis_tuser ? S_F_CLASS : S_A_CLASS;
        end
      end
      S_A_CLASS: begin
        if (size_big || size_cls >= CLASS_COUNT) begin
          res_off_d = '0;
          res_st_d  = ST_NOSPACE;
          state_d   = S_DONE;
        end else begin
          cls_d   = CLS_W'(size_cls);
          state_d = S_A_START;
        end
      end
      S_A_START: begin
        chk_idx_d  = '0;
        chk_addr_d = WORD_BASE[cls_q];
        rd_addr    = WORD_BASE[cls_q][WORD_W-1:0];
        rd_en      = WORD_BASE[cls_q] < WSUM_W'(MAP_WORDS);
        state_d    = S_A_SCAN;
      end
      S_A_SCAN: begin
        // fetch the next word while this one is checked
        rd_addr = next_addr[WORD_W-1:0];
        rd_en   = next_addr < WSUM_W'(MAP_WORDS);
        if (chk_addr_q >= WSUM_W'(MAP_WORDS)) begin
          res_off_d = '0;
          res_st_d  = ST_NOSPACE;
          state_d   = S_DONE;
        end else if (freebits != '0) begin
          hit_word_d = rd_word;
          free_d     = freebits;
          state_d    = S_A_HIT;
        end else if (CNT_W'(chk_idx_q) + CNT_W'(1) == CLASS_WORDS[cls_q]) begin
          res_off_d = '0;
          res_st_d  = ST_NOSPACE;
          state_d   = S_DONE;
        end else begin
          chk_idx_d  = chk_idx_q + IDX_W'(1);
          chk_addr_d = next_addr;
        end
      end
      S_A_HIT: begin
        we      = 1'b1;
        wr_data = hit_word_q | (MAP_BITS'(1) << first_set(free_q));
        chunk_d = {chk_idx_q, first_set(free_q)};
        state_d = S_A_OFF;
      end
      S_A_OFF: begin
        res_off_d = OFFSET_BITS'(alloc_off);
        res_st_d  = ST_OK;
        state_d   = S_DONE;
      end
      S_F_CLASS: begin
        cls_d   = free_cls;
        state_d = S_F_DIFF;
      end
      S_F_DIFF: begin
        if ((REL_CMP_W'(addr_q) < REL_CMP_W'(CLASS_BASE[cls_q])) ||
            (diff_full >= REL_CMP_W'(CLASS_BYTES[cls_q]))) begin
          res_off_d = '0;
          res_st_d  = ST_BADADDR;
          state_d   = S_DONE;
        end else begin
          diff_d  = BASE_W'(diff_full);
          state_d = S_F_IDX;
        end
      end
      S_F_IDX: begin
        if (fword >= WSUM_W'(MAP_WORDS)) begin
          res_off_d = '0;
          res_st_d  = ST_BADADDR;
          state_d   = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = fword[WORD_W-1:0];
          chk_addr_d = fword;
          bit_d      = fidx[BIT_W-1:0];
          state_d    = S_F_CHK;
        end
      end
      S_F_CHK: begin
        res_off_d = '0;
        if (!rd_word[bit_q]) begin
          res_st_d = ST_DOUBLE;
        end else begin
          we       = 1'b1;
          wr_data  = rd_word & ~(MAP_BITS'(1) << bit_q);
          res_st_d = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_off_d = res_off_q;
          out_st_d  = res_st_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (we) vld_q[wr_addr] <= 1'b1;
      if (rd_en) rvld_q <= vld_q[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    addr_q     <= addr_d;
    cls_q      <= cls_d;
    chk_idx_q  <= chk_idx_d;
    chk_addr_q <= chk_addr_d;
    hit_word_q <= hit_word_d;
    free_q     <= free_d;
    chunk_q    <= chunk_d;
    diff_q     <= diff_d;
    bit_q      <= bit_d;
    res_off_q  <= res_off_d;
    res_st_q   <= res_st_d;
    out_off_q  <= out_off_d;
    out_st_q   <= out_st_d;
  end

  // bitmap memory ports
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input accepted while a command is in work");

  a_scan_in_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SCAN) |-> (CNT_W'(chk_idx_q) < CLASS_WORDS[cls_q]))
    else $error("scan ran past the words of its class");

  a_offset_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (out_off_q != '0)) |-> (out_st_q == ST_OK))
    else $error("nonzero chunk offset with failing status");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> ((state_q == S_A_HIT) || (state_q == S_F_CHK)))
    else $error("bitmap written outside of mark or clear step");
`endif

endmodule
